// ----- hdl/altk_pkg.sv -----
// Shared types, character codes and scan mode codes for the assembly line tokenizer.
package altk_pkg;

  // scan modes
  localparam logic [2:0] MODE_BETWEEN = 3'd0;
  localparam logic [2:0] MODE_PLAIN   = 3'd1;
  localparam logic [2:0] MODE_DQUOTE  = 3'd2;
  localparam logic [2:0] MODE_SQUOTE  = 3'd3;
  localparam logic [2:0] MODE_COMMENT = 3'd4;

  // token types on an end marker
  localparam logic [1:0] TYPE_IDENT  = 2'd0;
  localparam logic [1:0] TYPE_UNTERM = 2'd1;
  localparam logic [1:0] TYPE_LONG   = 2'd2;

  // result kinds
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_BSL   = 8'h5C;

  localparam int COL_W = 16;

  // result queue
  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW    = 2;
  localparam int RQ_CW    = 3;

  typedef struct packed {
    logic             kind;
    logic [7:0]       ch;
    logic [1:0]       ttype;
    logic [COL_W-1:0] start;
    logic             last;
  } res_t;

  // results produced by one accepted word (cnt is 0, 1 or 2)
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic res_t mk_char(logic [7:0] c, logic [COL_W-1:0] st, logic lst);
    res_t r;
    r.kind  = KIND_CHAR;
    r.ch    = c;
    r.ttype = TYPE_IDENT;
    r.start = st;
    r.last  = lst;
    return r;
  endfunction

  function automatic res_t mk_end(logic [1:0] ty, logic [COL_W-1:0] st, logic lst);
    res_t r;
    r.kind  = KIND_END;
    r.ch    = 8'd0;
    r.ttype = ty;
    r.start = st;
    r.last  = lst;
    return r;
  endfunction

endpackage

// ----- hdl/altk_scan.sv -----
// Per-character scan state machine: token state registers and result generation.
module altk_scan #(
  parameter int MAX_TOKEN_LEN = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    ch,
  input  logic          line_end,
  output altk_pkg::push_t push
);
  import altk_pkg::*;

  localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);

  logic [2:0]       mode, mode_next;
  logic [LEN_W-1:0] len, len_next;
  logic [7:0]       prev, prev_next;
  logic [COL_W-1:0] col, col_next;
  logic [COL_W-1:0] start, start_next;
  logic [1:0]       ctype, ctype_next;

  logic is_sep, is_semi, is_dq, is_sq, in_tok, too_long, closes, starts;
  logic [7:0] quote_ch;

  assign is_sep   = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_COMMA);
  assign is_semi  = (ch == CH_SEMI);
  assign is_dq    = (ch == CH_DQ);
  assign is_sq    = (ch == CH_SQ);
  assign in_tok   = (mode == MODE_PLAIN) || (mode == MODE_DQUOTE) || (mode == MODE_SQUOTE);
  assign too_long = (len >= LEN_W'(MAX_TOKEN_LEN));
  assign quote_ch = (mode == MODE_DQUOTE) ? CH_DQ : CH_SQ;
  assign closes   = (ch == quote_ch) && (prev != CH_BSL);
  assign starts   = !is_sep && !is_semi;

  always_comb begin
    mode_next  = mode;
    len_next   = len;
    prev_next  = prev;
    col_next   = col;
    start_next = start;
    ctype_next = ctype;
    push       = '0;
    if (accept) begin
      if (line_end) begin
        if (in_tok) begin
          push.cnt = 2'd1;
          push.r0  = mk_end(ctype, start, 1'b1);
        end
        mode_next  = MODE_BETWEEN;
        len_next   = '0;
        ctype_next = TYPE_IDENT;
        col_next   = '0;
      end else begin
        if (col != '1) begin
          col_next = col + 1'b1;
        end
        if (in_tok && !too_long) begin
          if (mode == MODE_PLAIN) begin
            if (is_sep || is_semi) begin
              push.cnt   = 2'd1;
              push.r0    = mk_end(ctype, start, 1'b1);
              mode_next  = is_semi ? MODE_COMMENT : MODE_BETWEEN;
              len_next   = '0;
              ctype_next = TYPE_IDENT;
            end else begin
              push.cnt  = 2'd1;
              push.r0   = mk_char(ch, start, 1'b1);
              len_next  = len + 1'b1;
              prev_next = ch;
              if (is_dq) begin
                mode_next  = MODE_DQUOTE;
                ctype_next = TYPE_UNTERM;
              end else if (is_sq) begin
                mode_next  = MODE_SQUOTE;
                ctype_next = TYPE_UNTERM;
              end
            end
          end else begin
            // inside a literal: every char is kept, an unescaped matching quote closes
            push.r0   = mk_char(ch, start, !closes);
            len_next  = len + 1'b1;
            prev_next = ch;
            if (closes) begin
              push.cnt   = 2'd2;
              push.r1    = mk_end(TYPE_IDENT, start, 1'b1);
              mode_next  = MODE_BETWEEN;
              len_next   = '0;
              ctype_next = TYPE_IDENT;
            end else begin
              push.cnt = 2'd1;
            end
          end
        end else if (mode != MODE_COMMENT) begin
          // between tokens, possibly right after a too-long token closes
          if (in_tok) begin
            mode_next  = MODE_BETWEEN;
            len_next   = '0;
            ctype_next = TYPE_IDENT;
          end
          if (is_semi) begin
            mode_next = MODE_COMMENT;
          end else if (starts) begin
            start_next = col;
            len_next   = LEN_W'(1);
            prev_next  = ch;
            ctype_next = (is_dq || is_sq) ? TYPE_UNTERM : TYPE_IDENT;
            mode_next  = is_dq ? MODE_DQUOTE : (is_sq ? MODE_SQUOTE : MODE_PLAIN);
          end
          if (in_tok && starts) begin
            push.cnt = 2'd2;
            push.r0  = mk_end(TYPE_LONG, start, 1'b0);
            push.r1  = mk_char(ch, col, 1'b1);
          end else if (in_tok) begin
            push.cnt = 2'd1;
            push.r0  = mk_end(TYPE_LONG, start, 1'b1);
          end else if (starts) begin
            push.cnt = 2'd1;
            push.r0  = mk_char(ch, col, 1'b1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_BETWEEN;
      len   <= '0;
      prev  <= '0;
      col   <= '0;
      start <= '0;
      ctype <= TYPE_IDENT;
    end else begin
      mode  <= mode_next;
      len   <= len_next;
      prev  <= prev_next;
      col   <= col_next;
      start <= start_next;
      ctype <= ctype_next;
    end
  end

  a_len_max: assert property (@(posedge clk) disable iff (rst)
    len <= LEN_W'(MAX_TOKEN_LEN))
    else $error("token length above maximum");

  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    mode <= MODE_COMMENT)
    else $error("scan mode out of range");

  a_eol_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && line_end) |=> (col == '0) && (len == '0) && (mode == MODE_BETWEEN))
    else $error("line end did not reset column and token");

endmodule

// ----- hdl/altk_rq.sv -----
// Small result queue: takes up to two results per cycle, hands out one.
module altk_rq (
  input  logic            clk,
  input  logic            rst,
  input  altk_pkg::push_t push,
  input  logic            pop,
  output logic            room,
  output logic            valid,
  output altk_pkg::res_t  head
);
  import altk_pkg::*;

  res_t             mem [RQ_DEPTH];
  logic [RQ_AW-1:0] wr_ptr, rd_ptr;
  logic [RQ_CW-1:0] count;
  logic [RQ_AW-1:0] wr_ptr1;

  assign wr_ptr1 = wr_ptr + 1'b1;
  assign room    = (count <= RQ_CW'(RQ_DEPTH - 2));
  assign valid   = (count != '0);
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RQ_AW'(push.cnt);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + RQ_CW'(push.cnt) - RQ_CW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= RQ_CW'(RQ_DEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push.cnt != 2'd0) |-> room)
    else $error("results pushed without room");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> valid)
    else $error("result popped from empty queue");

endmodule

// ----- hdl/assembly_line_tokenizer_core.sv -----
// Top level of the assembly line tokenizer: scan logic plus result queue.
//
// Takes one source character word per cycle (or an end-of-line word) and
// emits token words: each token character tagged with the token's start
// column, then an end marker with the token type (identifier, unterminated
// quote, too long). Space, tab and comma separate; a semicolon outside a
// literal starts a comment to end of line. The per-word scan is a single
// registered pass, so a new input word is taken every cycle while the queue
// has room. Most words make zero or one result; a closing quote, or a
// too-long break on a character that starts a token, makes two. The output
// side delivers one result per cycle while m_tready is high, so the sustained
// rate is one input word per cycle; a run of two-result words stalls input.
// A four-entry result queue decouples the two sides; input is taken while at
// least two entries are free. m_tlast marks the last result of an input word.
module assembly_line_tokenizer_core #(
  parameter int MAX_TOKEN_LEN = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  input  logic        s_tuser,   // [0] line_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] out_char, [9:8] token_type,
                                 // [25:10] start_column, [31:26] zero
  output logic        m_tuser,   // [0] out_kind
  output logic        m_tlast    // last result of the input word
);
  import altk_pkg::*;

  logic  accept;
  logic  pop;
  push_t push;
  res_t  head;

  assign accept = s_tvalid && s_tready;
  assign pop    = m_tvalid && m_tready;

  altk_scan #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .ch       (s_tdata),
    .line_end (s_tuser),
    .push     (push)
  );

  altk_rq u_rq (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .room  (s_tready),
    .valid (m_tvalid),
    .head  (head)
  );

  assign m_tdata = {6'd0, head.start, head.ttype, head.ch};
  assign m_tuser = head.kind;
  assign m_tlast = head.last;

endmodule

// ----- test/assembly_line_tokenizer_core_tb.sv -----
// Testbench for assembly_line_tokenizer_core: directed and random lines, scoreboard check.
`timescale 1ns / 1ps

module assembly_line_tokenizer_core_tb;
  import altk_pkg::*;

  localparam int TOK_MAX = 64;
  localparam int RAND_ITEMS = 400;
  localparam int CYCLE_LIMIT = 1000000;

  localparam string PLAIN_SET = "abcdefghijklmnopqrstuvwxyz_0123456789.$@#";
  localparam string LIT_SET   = "ab01 ,\t;\\\\'\"";
  localparam string GAP_SET   = " ,\t";
  localparam string QUOTE_SET = "\"'";

  typedef struct packed {
    logic [7:0] ch;
    logic       eol;
  } src_word_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  ch;
    logic [1:0]  ttype;
    logic [15:0] col;
    logic        last;
  } tok_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;   // [7:0] ch
  logic        s_tuser = 1'b0;   // [0] line_end
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;          // [7:0] char, [9:8] type, [25:10] start column
  logic        m_tuser;          // [0] kind
  logic        m_tlast;

  src_word_t src_q[$];
  tok_word_t tok_exp_q[$];
  src_word_t next_word;
  tok_word_t want;

  int   errors = 0;
  int   accepted = 0;
  int   cycles = 0;
  int   pause_a = -1;
  int   pause_b = -1;
  int   calm_lo = -1;
  int   calm_hi = -1;
  logic word_taken = 1'b0;
  logic calm;

  // tokenizer state mirror
  logic [2:0]  scan_st  = MODE_BETWEEN;
  logic [6:0]  tok_len  = '0;
  logic [7:0]  prev_ch  = '0;
  logic [15:0] col_next = '0;
  logic [15:0] tok_col  = '0;
  logic [1:0]  tok_type = TYPE_IDENT;

  assign calm = (accepted >= calm_lo) && (accepted < calm_hi);

  assembly_line_tokenizer_core #(
    .MAX_TOKEN_LEN(TOK_MAX)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- prediction

  function automatic logic is_gap(input logic [7:0] c);
    return c == CH_SPACE || c == CH_COMMA || c == CH_TAB;
  endfunction

  function automatic void push_tok_word(input logic kind, input logic [7:0] c,
                                        input logic [1:0] ty);
    tok_word_t w;
    w.kind  = kind;
    w.ch    = c;
    w.ttype = ty;
    w.col   = tok_col;
    w.last  = 1'b0;
    tok_exp_q.push_back(w);
  endfunction

  function automatic void add_char(input logic [7:0] c);
    push_tok_word(KIND_CHAR, c, TYPE_IDENT);
    tok_len = tok_len + 7'd1;
    prev_ch = c;
  endfunction

  function automatic void close_token(input logic [1:0] ty);
    push_tok_word(KIND_END, 8'd0, ty);
    scan_st  = MODE_BETWEEN;
    tok_len  = '0;
    tok_type = TYPE_IDENT;
  endfunction

  function automatic void scan_inside(input logic [7:0] c);
    logic closes;
    if (scan_st == MODE_PLAIN) begin
      if (is_gap(c)) begin
        close_token(tok_type);
      end else if (c == CH_SEMI) begin
        close_token(tok_type);
        scan_st = MODE_COMMENT;
      end else begin
        // a quote in a plain token opens a literal
        if (c == CH_DQ) begin
          scan_st  = MODE_DQUOTE;
          tok_type = TYPE_UNTERM;
        end else if (c == CH_SQ) begin
          scan_st  = MODE_SQUOTE;
          tok_type = TYPE_UNTERM;
        end
        add_char(c);
      end
    end else begin
      closes = (c == ((scan_st == MODE_DQUOTE) ? CH_DQ : CH_SQ)) && (prev_ch != CH_BSL);
      add_char(c);
      if (closes) close_token(TYPE_IDENT);
    end
  endfunction

  function automatic void scan_fresh(input logic [7:0] c, input logic [15:0] col);
    if (is_gap(c)) begin
      // separator between tokens: nothing to do
    end else if (c == CH_SEMI) begin
      scan_st = MODE_COMMENT;
    end else begin
      tok_col  = col;
      tok_len  = '0;
      prev_ch  = '0;
      tok_type = TYPE_IDENT;
      scan_st  = MODE_PLAIN;
      scan_inside(c);
    end
  endfunction

  function automatic void tokenize_word(input logic [7:0] c, input logic eol);
    int          n0;
    logic [15:0] col;
    n0 = tok_exp_q.size();
    if (eol) begin
      if (scan_st >= MODE_PLAIN && scan_st <= MODE_SQUOTE) close_token(tok_type);
      scan_st  = MODE_BETWEEN;
      tok_len  = '0;
      tok_type = TYPE_IDENT;
      col_next = '0;
    end else begin
      col = col_next;
      if (col_next != 16'hFFFF) col_next = col_next + 16'd1;
      if (scan_st == MODE_BETWEEN) begin
        scan_fresh(c, col);
      end else if (scan_st >= MODE_PLAIN && scan_st <= MODE_SQUOTE) begin
        if (tok_len >= TOK_MAX) begin
          close_token(TYPE_LONG);
          scan_fresh(c, col);
        end else begin
          scan_inside(c);
        end
      end else if (scan_st != MODE_COMMENT) begin
        scan_st = MODE_BETWEEN;
        scan_fresh(c, col);
      end
    end
    if (tok_exp_q.size() > n0) tok_exp_q[tok_exp_q.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic logic [7:0] pick(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic void put_ch(input logic [7:0] c);
    src_word_t w;
    w.ch  = c;
    w.eol = 1'b0;
    src_q.push_back(w);
  endfunction

  function automatic void put_eol();
    src_word_t w;
    w.ch  = 8'($urandom);   // ch is don't-care on a line end
    w.eol = 1'b1;
    src_q.push_back(w);
  endfunction

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_ch(s[i]);
  endfunction

  // one token: plain, quoted or raw noise; now and then near the length limit
  function automatic void put_token();
    int         sel;
    int         n;
    int         r;
    logic [7:0] q;
    sel = $urandom_range(0, 99);
    n = ($urandom_range(0, 99) < 15) ? $urandom_range(TOK_MAX - 2, TOK_MAX + 3)
                                     : $urandom_range(1, 8);
    if (sel < 45) begin
      for (int i = 0; i < n; i++) begin
        r = $urandom_range(0, 99);
        put_ch((r < 80) ? pick(PLAIN_SET) : (r < 85) ? pick(QUOTE_SET) : 8'($urandom));
      end
    end else if (sel < 85) begin
      q = (sel < 70) ? CH_DQ : CH_SQ;
      put_ch(q);
      for (int i = 1; i < n; i++)
        put_ch(($urandom_range(0, 99) < 80) ? pick(LIT_SET) : 8'($urandom));
      if ($urandom_range(0, 99) < 80) put_ch(q);
    end else begin
      for (int i = 0; i < n; i++) put_ch(8'($urandom));
    end
  endfunction

  // ---------------------------------------------------------------- driver

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || word_taken) begin
      if (src_q.size() == 0 ||
          ((accepted == pause_a || accepted == pause_b) && tok_exp_q.size() != 0) ||
          (!calm && $urandom_range(0, 99) < 33)) begin
        s_tvalid <= 1'b0;
      end else begin
        next_word = src_q.pop_front();
        s_tdata  <= next_word.ch;
        s_tuser  <= next_word.eol;
        s_tvalid <= 1'b1;
      end
    end
  end

  always @(negedge clk) begin
    m_tready <= !rst && (calm || $urandom_range(0, 99) >= 33);
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    word_taken = 1'b0;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (tok_exp_q.size() == 0) begin
          $error("unexpected result word: tdata %0h tuser %0b tlast %0b",
                 m_tdata, m_tuser, m_tlast);
          errors++;
        end else begin
          want = tok_exp_q.pop_front();
          if (m_tuser !== want.kind) begin
            $error("out_kind: expected %0d, got %0d", want.kind, m_tuser);
            errors++;
          end
          if (m_tdata[7:0] !== want.ch) begin
            $error("out_char: expected %0h, got %0h", want.ch, m_tdata[7:0]);
            errors++;
          end
          if (m_tdata[9:8] !== want.ttype) begin
            $error("token_type: expected %0d, got %0d", want.ttype, m_tdata[9:8]);
            errors++;
          end
          if (m_tdata[25:10] !== want.col) begin
            $error("start_column: expected %0d, got %0d", want.col, m_tdata[25:10]);
            errors++;
          end
          if (m_tlast !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, m_tlast);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        tokenize_word(s_tdata, s_tuser);
        accepted++;
        word_taken = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- run control

  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk) cycles++;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int dir_n;
    int ntok;

    // directed: zero and all-ones bytes, escaped quote, closed literal,
    // quote inside a plain token, unterminated literal at line end
    put_ch(8'h00);
    put_ch(8'hFF);
    put_text(" \"\\\" \", b'\t");
    put_eol();
    // semicolon ends a token and comments out the rest of the line
    put_text("q;z w");
    put_eol();
    // quote after an escaped backslash still counts as escaped
    put_text("'\\\\'");
    put_eol();
    put_eol();               // empty line gives nothing
    put_text("e");
    put_eol();
    dir_n = src_q.size();

    // full-length token at line end, then one character over the limit
    for (int i = 0; i < TOK_MAX; i++) put_ch(pick(PLAIN_SET));
    put_eol();
    for (int i = 0; i <= TOK_MAX; i++) put_ch(pick(PLAIN_SET));
    put_eol();

    while (src_q.size() < dir_n + RAND_ITEMS) begin
      ntok = $urandom_range(1, 5);
      for (int t = 0; t < ntok; t++) begin
        if (t > 0 || $urandom_range(0, 1))
          repeat ($urandom_range(1, 2)) put_ch(pick(GAP_SET));
        put_token();
      end
      if ($urandom_range(0, 99) < 25) begin
        put_ch(CH_SEMI);
        repeat ($urandom_range(0, 6)) put_ch(8'($urandom));
      end
      put_eol();
    end

    pause_a = dir_n;
    pause_b = dir_n + 200;
    calm_lo = dir_n + 250;
    calm_hi = dir_n + 350;

    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (src_q.size() != 0 || s_tvalid) @(posedge clk);
    while (tok_exp_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/altk_pkg.sv
hdl/altk_scan.sv
hdl/altk_rq.sv
hdl/assembly_line_tokenizer_core.sv
test/assembly_line_tokenizer_core_tb.sv
